// ===== sv/lpf_pkg.sv =====
// Shared constants for the largest prime factor core.
package lpf_pkg;

  // Default operand width.
  localparam int unsigned NUM_WIDTH_DEF = 31;

  // Result status codes.
  localparam int unsigned STATUS_W = 2;
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_FOUND = 2'd0;
  localparam status_t STATUS_PRIME = 2'd1;
  localparam status_t STATUS_SMALL = 2'd2;

endpackage

// ===== sv/largest_prime_factor_core.sv =====
// Largest proper prime factor by trial division over a shared restoring divider.
// Trials run for each divisor d from 2 until d*d exceeds the rest still left after
// removing factors, plus one per factor removed. Worst case (a prime near 2^31) is
// about 46k trials. Each trial runs the divider, which gives one quotient bit per
// cycle. One item is in work at a time.
// Reset: synchronous, active-low rst_n; idle, no result.
module largest_prime_factor_core
  import lpf_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // in_tdata: [NUM_WIDTH-1:0] number
  input  logic [((NUM_WIDTH+7)/8)*8-1:0]             in_tdata,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // out_tdata: [NUM_WIDTH-1:0] factor, [NUM_WIDTH+1:NUM_WIDTH] status
  output logic [((NUM_WIDTH+STATUS_W+7)/8)*8-1:0]    out_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready
);

  localparam int unsigned OUT_W = ((NUM_WIDTH + STATUS_W + 7) / 8) * 8;
  localparam int unsigned CNT_W = $clog2(NUM_WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_DEC  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NUM_WIDTH-1:0]   num_r, num_nxt;
  logic [NUM_WIDTH-1:0]   rest_r, rest_nxt;
  logic [NUM_WIDTH-1:0]   d_r, d_nxt;
  logic [NUM_WIDTH-1:0]   best_r, best_nxt;
  logic                   small_r, small_nxt;
  logic [NUM_WIDTH-1:0]   rem_r, rem_nxt;
  logic [NUM_WIDTH-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [NUM_WIDTH:0]     shift;
  logic [NUM_WIDTH+1:0]   sub;
  logic                   ge;
  logic [NUM_WIDTH-1:0]   in_num;
  logic [NUM_WIDTH-1:0]   res_factor;
  status_t                res_status;

  assign in_num     = in_tdata[NUM_WIDTH-1:0];
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // Shared divider step: shift in one dividend bit, subtract divisor if it fits
  assign shift = {rem_r, quo_r[NUM_WIDTH-1]};
  assign sub   = {1'b0, shift} - {2'b00, d_r};
  assign ge    = ~sub[NUM_WIDTH+1];

  // Final result from the kept best factor
  always_comb begin
    if (small_r) begin
      res_factor = '0;
      res_status = STATUS_SMALL;
    end else if (best_r == num_r) begin
      res_factor = '0;
      res_status = STATUS_PRIME;
    end else begin
      res_factor = best_r;
      res_status = STATUS_FOUND;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    rest_nxt      = rest_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    small_nxt     = small_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          num_nxt   = in_num;
          rest_nxt  = in_num;
          best_nxt  = '0;
          d_nxt     = NUM_WIDTH'(2);
          rem_nxt   = '0;
          quo_nxt   = in_num;
          cnt_nxt   = '0;
          small_nxt = (in_num <= NUM_WIDTH'(1));
          state_nxt = (in_num <= NUM_WIDTH'(1)) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle
        rem_nxt = ge ? sub[NUM_WIDTH-1:0] : shift[NUM_WIDTH-1:0];
        quo_nxt = {quo_r[NUM_WIDTH-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        // quo_r = rest / d, rem_r = rest % d
        if (d_r > quo_r) begin
          if (rest_r > NUM_WIDTH'(1)) begin
            best_nxt = rest_r;
          end
          state_nxt = ST_FIN;
        end else begin
          if (rem_r == '0) begin
            best_nxt = d_r;
            rest_nxt = quo_r;
            quo_nxt  = quo_r;
          end else begin
            d_nxt   = d_r + NUM_WIDTH'(1);
            quo_nxt = rest_r;
          end
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = OUT_W'({res_status, res_factor});
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    rest_r     <= rest_nxt;
    d_r        <= d_nxt;
    best_r     <= best_nxt;
    small_r    <= small_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking stream testbench for the largest prime factor core.
module tb;
  import lpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_W = NUM_WIDTH_DEF;
  localparam int unsigned IN_W  = ((NUM_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((NUM_W + STATUS_W + 7) / 8) * 8;
  localparam longint unsigned NUM_MAX = (64'd1 << NUM_W) - 1;

  typedef struct packed {
    logic [NUM_W-1:0] factor;
    status_t          status;
  } factor_result_t;

  typedef struct {
    logic [NUM_W-1:0] number;
    bit               drain;  // hold this item until all results are back
  } pending_number_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic [IN_W-1:0]  in_tdata = '0;   // [NUM_W-1:0] number
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;       // [NUM_W-1:0] factor, [NUM_W+1:NUM_W] status
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  pending_number_t  pending_numbers[$];
  factor_result_t   expected_factors[$];
  int unsigned      queued_count = 0;
  int unsigned      sent_count = 0;
  int unsigned      seen_count = 0;
  int unsigned      fail_count = 0;
  longint unsigned  cycle_count = 0;
  longint unsigned  cycle_limit = 200000;

  // driver and monitor working variables
  int unsigned      gap_left = 0;
  int unsigned      stall_left = 0;
  logic             valid_n;
  logic             ready_n;
  pending_number_t  next_item;
  factor_result_t   got;
  factor_result_t   want;

  largest_prime_factor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #1 clk = ~clk;

  // Largest prime below the number that divides it, with its status.
  function automatic factor_result_t largest_proper_prime(logic [NUM_W-1:0] number);
    longint unsigned rest;
    longint unsigned best;
    longint unsigned d;
    factor_result_t  r;
    rest = number;
    best = 0;
    r.factor = '0;
    if (rest <= 1) begin
      r.status = STATUS_SMALL;
      return r;
    end
    for (d = 2; d <= rest / d; d++) begin
      while (rest % d == 0) begin
        best = d;
        rest = rest / d;
      end
    end
    if (rest > 1) best = rest;
    if (best == number) begin
      r.status = STATUS_PRIME;
    end else begin
      r.status = STATUS_FOUND;
      r.factor = best[NUM_W-1:0];
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned s;
    s = 0;
    while ((s + 1) * (s + 1) <= n) s++;
    return s;
  endfunction

  // Queue one number and widen the run limit by a bound on its worst run time.
  task automatic push_number(longint unsigned n, bit drain);
    pending_number_t p;
    p.number = n[NUM_W-1:0];
    p.drain  = drain;
    pending_numbers = {pending_numbers, p};
    queued_count++;
    cycle_limit += 8 * ((int_sqrt(n & NUM_MAX) + 64) * (NUM_W + 2) + 16);
  endtask

  // Product of random primes below one hundred that still fits the field.
  function automatic longint unsigned smooth_number();
    int unsigned     primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                    43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    longint unsigned v;
    longint unsigned p;
    v = 1;
    for (int k = 0; k < 40; k++) begin
      p = primes[$urandom_range(0, 24)];
      if (v * p <= NUM_MAX) v = v * p;
    end
    return v;
  endfunction

  // Drive input items from the pending queue with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      gap_left = 0;
    end else begin
      valid_n = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_factors = {expected_factors,
                            largest_proper_prime(in_tdata[NUM_W-1:0])};
        sent_count++;
        valid_n = 1'b0;
        gap_left = ((sent_count / 16) % 3 == 1) ? 0 : $urandom_range(0, 5);
      end
      if (!valid_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_numbers.size() > 0 &&
                     !(pending_numbers[0].drain && expected_factors.size() != 0)) begin
          next_item = pending_numbers.pop_front();
          in_tdata <= IN_W'(next_item.number);
          valid_n = 1'b1;
        end
      end
      in_tvalid <= valid_n;
    end
  end

  // Check each result item against the oldest prediction; stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      ready_n = out_tready;
      if (out_tvalid && out_tready) begin
        got.factor = out_tdata[NUM_W-1:0];
        got.status = out_tdata[NUM_W+STATUS_W-1:NUM_W];
        if (expected_factors.size() == 0) begin
          $error("unexpected result: factor %0d status %0d", got.factor, got.status);
          fail_count++;
        end else begin
          want = expected_factors.pop_front();
          if (got.factor !== want.factor) begin
            $error("factor: expected %0d, actual %0d", want.factor, got.factor);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
        end
        seen_count++;
        stall_left = ((seen_count / 16) % 3 == 2) ? 0 : $urandom_range(0, 5);
        ready_n = (stall_left == 0);
      end else if (!out_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) ready_n = 1'b1;
      end
      out_tready <= ready_n;
    end
  end

  // Abort on a run that goes far past the slowest correct one.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("largest_prime_factor_core test failed");
      $finish;
    end
  end

  initial begin
    longint unsigned v;
    int unsigned     pick;

    // Directed: small inputs, primes, prime powers and field extremes.
    push_number(0, 1'b0);
    push_number(1, 1'b0);
    push_number(2, 1'b0);
    push_number(3, 1'b0);
    push_number(4, 1'b0);
    push_number(6, 1'b0);
    push_number(8, 1'b0);
    push_number(9, 1'b0);
    push_number(15, 1'b0);
    push_number(25, 1'b0);
    push_number(49, 1'b0);
    push_number(97, 1'b0);
    push_number(961, 1'b0);
    push_number(1024, 1'b0);
    push_number(65521, 1'b0);
    push_number(65536, 1'b0);
    push_number(64'h4000_0000, 1'b0);
    push_number(1162261467, 1'b0);
    push_number(NUM_MAX - 1, 1'b0);
    push_number(NUM_MAX, 1'b0);

    // Random: mostly small numbers, some smooth and shifted wide ones.
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        v = $urandom_range(0, 65535);
      end else if (pick < 17) begin
        v = smooth_number();
      end else if (pick < 19) begin
        v = $urandom_range(0, (1 << 20) - 1);
      end else begin
        v = longint'($urandom_range(1, 7)) << $urandom_range(0, NUM_W - 1);
        while (v > NUM_MAX) v = v >> 1;
      end
      push_number(v, (i == 0) || (i == 50));
    end

    // Hold reset, then release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all items to go in and all results to come back.
    while (sent_count < queued_count) @(posedge clk);
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("largest_prime_factor_core test passed");
    end else begin
      $display("largest_prime_factor_core test failed");
    end
    $finish;
  end

endmodule
